>>> design/dmht_pkg.sv
`timescale 1ns / 1ps
// dmht_pkg: shared widths, operation and status codes, controller/datapath structs
package dmht_pkg;

  // fixed widths of the word fields
  localparam int KEY_W      = 31;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int SLOT_OUT_W = 4;
  localparam int CNT_OUT_W  = 16;
  localparam int OCC_OUT_W  = 4;

  // defaults for the top level parameters
  localparam int DEF_TABLE_SLOTS = 11;
  localparam int DEF_COUNT_BITS  = 16;

  // operation codes, any other code is a size query
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_NEW     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INCR    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_COLLIDE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SIZE    = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic clr_step;   // write one zero entry of the clearing pass
    logic load;       // capture the input word
    logic mod_start;  // start the slot computation
    logic rd;         // read the addressed slot
    logic exec;       // update the slot and load the result register
  } dmht_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_is_size; // word on the input is a size query
    logic mod_done;   // slot index ready
    logic clr_last;   // clearing pass at its last entry
    logic out_free;   // result register can take a word
  } dmht_sts_t;

endpackage

>>> design/dmht_ram.sv
`timescale 1ns / 1ps
// dmht_ram: generic single write port, single read port ram with registered read
module dmht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/dmht_mod.sv
`timescale 1ns / 1ps
// dmht_mod: key modulo slot count by reciprocal multiplication, product then remainder registered
module dmht_mod import dmht_pkg::*; #(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [KEY_W-1:0]               key,
  output logic                           done,
  output logic [$clog2(TABLE_SLOTS)-1:0] slot
);

  localparam int SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int RECIP_W = KEY_W + 1;
  localparam int PROD_W  = KEY_W + RECIP_W;
  localparam int SHIFT   = KEY_W + SLOT_W;
  localparam int QUO_W   = PROD_W - SHIFT;
  // ceil(2^SHIFT / TABLE_SLOTS) gives the exact quotient for every key
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(TABLE_SLOTS - 1)) / 64'(TABLE_SLOTS);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  logic [KEY_W-1:0]  key_hold;
  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  quo;
  logic [KEY_W-1:0]  rem_full;
  logic [SLOT_W-1:0] rem;
  logic              stage2;

  // quotient from the product, remainder by one constant multiply and subtract
  always_comb begin
    quo      = prod[PROD_W-1:SHIFT];
    rem_full = key_hold - KEY_W'(quo) * KEY_W'(TABLE_SLOTS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage2 <= start;
      done   <= stage2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_hold <= key;
      prod     <= PROD_W'(key) * PROD_W'(RECIP);
    end
    if (stage2) begin
      rem <= rem_full[SLOT_W-1:0];
    end
  end

  assign slot = rem;

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !stage2)
    else $error("modulo unit restarted while busy");

endmodule

>>> design/dmht_dp.sv
`timescale 1ns / 1ps
// dmht_dp: datapath with slot store, modulo unit, occupancy count and result register
module dmht_dp import dmht_pkg::*; #(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dmht_cmd_t             cmd,
  output dmht_sts_t             sts,
  input  logic [KIND_W-1:0]     kind,
  input  logic [KEY_W-1:0]      lookup_key,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [STATUS_W-1:0]   status,
  output logic [SLOT_OUT_W-1:0] slot_index,
  output logic [CNT_OUT_W-1:0]  entry_count,
  output logic [OCC_OUT_W-1:0]  occupied_slots
);

  localparam int SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int OCC_W   = $clog2(TABLE_SLOTS + 1);
  localparam int ENTRY_W = KEY_W + COUNT_BITS;

  logic [KIND_W-1:0]  kind_q;
  logic [KEY_W-1:0]   key_q;
  logic [SLOT_W-1:0]  slot;
  logic [SLOT_W-1:0]  clr_addr;
  logic [OCC_W-1:0]   occ_total;
  logic               mod_done;

  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;

  logic [KEY_W-1:0]      rd_key;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic                  slot_used;
  logic                  key_hit;
  logic                  do_write;
  logic [KEY_W-1:0]      key_new;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [COUNT_BITS-1:0] cnt_res;
  logic [SLOT_W-1:0]     slot_res;
  logic [OCC_W-1:0]      occ_new;
  logic [STATUS_W-1:0]   st;

  logic [CNT_OUT_W+COUNT_BITS-1:0] cnt_pad;
  logic [SLOT_OUT_W+SLOT_W-1:0]    slot_pad;
  logic [OCC_OUT_W+OCC_W-1:0]      occ_pad;

  // started on the accepting edge, so it takes the key straight from the input
  dmht_mod #(.TABLE_SLOTS(TABLE_SLOTS)) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mod_start),
    .key   (lookup_key),
    .done  (mod_done),
    .slot  (slot)
  );

  dmht_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SLOTS)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd),
    .rd_addr (slot),
    .rd_data (rd_data)
  );

  // entry update
  always_comb begin
    rd_key    = rd_data[ENTRY_W-1:COUNT_BITS];
    rd_cnt    = rd_data[COUNT_BITS-1:0];
    slot_used = (rd_cnt != '0);
    key_hit   = (rd_key == key_q);
    do_write  = 1'b0;
    key_new   = key_q;
    cnt_new   = rd_cnt;
    cnt_res   = rd_cnt;
    slot_res  = slot;
    occ_new   = occ_total;
    st        = ST_SIZE;
    if (kind_q == KIND_INSERT) begin
      if (!slot_used) begin
        do_write = 1'b1;
        cnt_new  = COUNT_BITS'(1);
        occ_new  = occ_total + OCC_W'(1);
        st       = ST_NEW;
      end else if (key_hit) begin
        do_write = 1'b1;
        if (rd_cnt != '1) begin
          cnt_new = rd_cnt + COUNT_BITS'(1);
        end
        st = ST_INCR;
      end else begin
        st = ST_COLLIDE;
      end
      cnt_res = cnt_new;
    end else if (kind_q == KIND_REMOVE) begin
      if (slot_used && key_hit) begin
        do_write = 1'b1;
        key_new  = '0;
        cnt_new  = '0;
        if (occ_total != '0) begin
          occ_new = occ_total - OCC_W'(1);
        end
        st = ST_REMOVED;
      end else begin
        st = ST_ABSENT;
      end
      cnt_res = cnt_new;
    end else begin
      cnt_res  = '0;
      slot_res = '0;
    end
  end

  // clearing pass shares the write port
  always_comb begin
    if (cmd.clr_step) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else begin
      wr_en   = cmd.exec && do_write;
      wr_addr = slot;
      wr_data = {key_new, cnt_new};
    end
  end

  assign cnt_pad  = {{CNT_OUT_W{1'b0}}, cnt_res};
  assign slot_pad = {{SLOT_OUT_W{1'b0}}, slot_res};
  assign occ_pad  = {{OCC_OUT_W{1'b0}}, occ_new};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      key_q  <= lookup_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      occ_total <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + SLOT_W'(1);
      end
      if (cmd.exec) begin
        occ_total <= occ_new;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status         <= st;
      slot_index     <= slot_pad[SLOT_OUT_W-1:0];
      entry_count    <= cnt_pad[CNT_OUT_W-1:0];
      occupied_slots <= occ_pad[OCC_OUT_W-1:0];
    end
  end

  assign sts.in_is_size = (kind != KIND_INSERT) && (kind != KIND_REMOVE);
  assign sts.mod_done   = mod_done;
  assign sts.clr_last   = (clr_addr == SLOT_W'(TABLE_SLOTS - 1));
  assign sts.out_free   = !out_valid || !out_stall;

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
      occ_total <= OCC_W'(TABLE_SLOTS))
    else $error("occupied slot count beyond table size");

  a_exec_valid: assert property (@(posedge clk) disable iff (rst) cmd.exec |=> out_valid)
    else $error("result word lost after update");

  a_clr_quiet: assert property (@(posedge clk) disable iff (rst) cmd.clr_step |-> !out_valid)
    else $error("result pending during clearing pass");

endmodule

>>> design/dmht_ctrl.sv
`timescale 1ns / 1ps
// dmht_ctrl: sequencing of clearing pass, slot computation, read and update
module dmht_ctrl import dmht_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  dmht_sts_t sts,
  output dmht_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_EXEC
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_stall_next;
  logic   accept;

  assign accept = in_valid && !in_stall;

  always_comb begin
    cmd           = '0;
    state_next    = state;
    in_stall_next = in_stall;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next    = S_IDLE;
          in_stall_next = 1'b0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load      = 1'b1;
          cmd.mod_start = !sts.in_is_size;
          state_next    = sts.in_is_size ? S_EXEC : S_MOD;
          in_stall_next = 1'b1;
        end
      end
      S_MOD: begin
        if (sts.mod_done) begin
          cmd.rd     = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.exec      = 1'b1;
          state_next    = S_IDLE;
          in_stall_next = 1'b0;
        end
      end
      default: begin
        state_next    = S_IDLE;
        in_stall_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      in_stall <= 1'b1;
    end else begin
      state    <= state_next;
      in_stall <= in_stall_next;
    end
  end

  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
      state == S_CLEAR |-> in_stall)
    else $error("input open during clearing pass");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
      !in_stall |-> state == S_IDLE)
    else $error("input open while an operation is in flight");

  a_exec_free: assert property (@(posedge clk) disable iff (rst) cmd.exec |-> sts.out_free)
    else $error("update issued while result register occupied");

endmodule

>>> design/direct_mapped_counting_hash_table.sv
`timescale 1ns / 1ps
// direct_mapped_counting_hash_table: counting hash table top level
//
//   channel  direction  handshake            word fields
//   input    in         in_valid / in_stall   kind, lookup_key
//   result   out        out_valid / out_stall status, slot_index, entry_count, occupied_slots
//
// after reset the slot store is cleared entry by entry with in_stall high
// insert and remove first find the slot index by reciprocal multiplication,
//   then do one ram read and one read-modify-write step that loads the result register
// a size query skips the slot index and the ram read, it never touches the store
// a new word is taken while the previous result still waits in the output register;
//   the update only stalls if that register is still full when the next result is ready
module direct_mapped_counting_hash_table import dmht_pkg::*; #(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  // input words
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [KIND_W-1:0]     kind,
  input  logic [KEY_W-1:0]      lookup_key,
  // result words
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   status,
  output logic [SLOT_OUT_W-1:0] slot_index,
  output logic [CNT_OUT_W-1:0]  entry_count,
  output logic [OCC_OUT_W-1:0]  occupied_slots
);

  // command and status between sequencer and datapath
  dmht_cmd_t cmd;
  dmht_sts_t sts;

  // sequencer: clearing pass, then one operation at a time
  dmht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: slot store, modulo unit, occupancy and the result register
  dmht_dp #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .kind           (kind),
    .lookup_key     (lookup_key),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .status         (status),
    .slot_index     (slot_index),
    .entry_count    (entry_count),
    .occupied_slots (occupied_slots)
  );

endmodule
